// ===== design/autoseg_pkg.sv =====
package autoseg_pkg;

   localparam int VALUE_W = 24;
   localparam logic [VALUE_W-1:0] VALUE_MAX = 24'd9999999;

   // upper bounds of each decimal point range, a value on the bound takes the finer range
   localparam logic [VALUE_W-1:0] POINT_LIMIT_3 = 24'd9900;
   localparam logic [VALUE_W-1:0] POINT_LIMIT_2 = 24'd99900;
   localparam logic [VALUE_W-1:0] POINT_LIMIT_1 = 24'd999900;

   typedef logic [1:0] point_type;
   localparam point_type POINT_DIGIT0 = 2'd0;
   localparam point_type POINT_DIGIT1 = 2'd1;
   localparam point_type POINT_DIGIT2 = 2'd2;
   localparam point_type POINT_DIGIT3 = 2'd3;

   // reciprocals for exact truncating division of any 24-bit value
   localparam int MULT_W = 25;
   localparam int PROD_W = VALUE_W + MULT_W;
   localparam logic [MULT_W-1:0] RECIP_ONE      = 25'd1;
   localparam logic [MULT_W-1:0] RECIP_TEN      = 25'd26843546;  // 2^28 / 10
   localparam logic [MULT_W-1:0] RECIP_HUNDRED  = 25'd21474837;  // 2^31 / 100
   localparam logic [MULT_W-1:0] RECIP_THOUSAND = 25'd17179870;  // 2^34 / 1000

   // scaled value never exceeds 9999
   localparam int SCALED_W     = 14;
   localparam int SMALL_MULT_W = 15;
   localparam int SMALL_PROD_W = SCALED_W + SMALL_MULT_W;
   localparam logic [SMALL_MULT_W-1:0] DIV10_MULT   = 15'd26215;  // 2^18 / 10
   localparam logic [SMALL_MULT_W-1:0] DIV100_MULT  = 15'd20972;  // 2^21 / 100
   localparam logic [SMALL_MULT_W-1:0] DIV1000_MULT = 15'd16778;  // 2^24 / 1000

   localparam int SEG_W = 8;
   localparam int SEG_POINT_BIT = 7;
   localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;

   typedef struct packed {
      logic [PROD_W-1:0] product;
      point_type         point;
   } range_word_type;

   function automatic logic [MULT_W-1:0] recip_mult(input point_type point);
      logic [MULT_W-1:0] m;
      unique case (point)
         POINT_DIGIT3: m = RECIP_ONE;
         POINT_DIGIT2: m = RECIP_TEN;
         POINT_DIGIT1: m = RECIP_HUNDRED;
         default:      m = RECIP_THOUSAND;
      endcase
      return m;
   endfunction

   function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
      logic [SEG_W-1:0] s;
      unique case (digit)
         4'd0:    s = 8'hC0;
         4'd1:    s = 8'hF9;
         4'd2:    s = 8'hA4;
         4'd3:    s = 8'hB0;
         4'd4:    s = 8'h99;
         4'd5:    s = 8'h92;
         4'd6:    s = 8'h82;
         4'd7:    s = 8'hF8;
         4'd8:    s = 8'h80;
         4'd9:    s = 8'h90;
         default: s = SEG_BLANK;
      endcase
      return s;
   endfunction

endpackage

// ===== design/autoseg_range.sv =====
module autoseg_range (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [autoseg_pkg::VALUE_W-1:0]     in_value,
   output logic                                out_valid,
   input  logic                                out_ready,
   output autoseg_pkg::range_word_type         out_word
);
   import autoseg_pkg::*;

   logic                 a_valid_ff;
   logic [VALUE_W-1:0]   value_ff;
   logic [VALUE_W-1:0]   value_in;
   point_type            point_a_ff;
   point_type            point_a_in;
   logic                 b_valid_ff;
   logic [PROD_W-1:0]    product_ff;
   logic [PROD_W-1:0]    product_in;
   point_type            point_b_ff;
   logic                 a_adv;
   logic                 b_adv;

   assign b_adv    = !b_valid_ff || out_ready;
   assign a_adv    = !a_valid_ff || b_adv;
   assign in_ready = a_adv;

   always_comb begin
      value_in = (in_value > VALUE_MAX) ? VALUE_MAX : in_value;
      if (value_in <= POINT_LIMIT_3) begin
         point_a_in = POINT_DIGIT3;
      end else if (value_in <= POINT_LIMIT_2) begin
         point_a_in = POINT_DIGIT2;
      end else if (value_in <= POINT_LIMIT_1) begin
         point_a_in = POINT_DIGIT1;
      end else begin
         point_a_in = POINT_DIGIT0;
      end
   end

   // divide by 10^(3-point) as multiply by reciprocal, shift happens downstream
   assign product_in = PROD_W'(value_ff) * PROD_W'(recip_mult(point_a_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_adv) begin
            a_valid_ff <= in_valid;
         end
         if (b_adv) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv) begin
         value_ff   <= value_in;
         point_a_ff <= point_a_in;
      end
      if (b_adv) begin
         product_ff <= product_in;
         point_b_ff <= point_a_ff;
      end
   end

   assign out_valid        = b_valid_ff;
   assign out_word.product = product_ff;
   assign out_word.point   = point_b_ff;

endmodule

// ===== design/autoseg_digits.sv =====
module autoseg_digits #(
   parameter int DIGIT_COUNT = 4
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             in_valid,
   output logic                                             in_ready,
   input  autoseg_pkg::range_word_type                      in_word,
   output logic                                             out_valid,
   input  logic                                             out_ready,
   output logic [DIGIT_COUNT-1:0][autoseg_pkg::SEG_W-1:0]   out_frames
);
   import autoseg_pkg::*;

   logic                                c_valid_ff;
   logic [SCALED_W-1:0]                 scaled_ff;
   logic [SCALED_W-1:0]                 scaled_in;
   logic [SMALL_PROD_W-1:0]             p10_ff;
   logic [SMALL_PROD_W-1:0]             p100_ff;
   logic [SMALL_PROD_W-1:0]             p1000_ff;
   point_type                           point_c_ff;
   logic                                d_valid_ff;
   logic [DIGIT_COUNT-1:0][SEG_W-1:0]   frames_ff;
   logic [DIGIT_COUNT-1:0][SEG_W-1:0]   frames_in;
   logic [10:0]                         q10;
   logic [7:0]                          q100;
   logic [4:0]                          q1000;
   logic [SCALED_W-1:0]                 rem0;
   logic [10:0]                         rem1;
   logic [7:0]                          rem2;
   logic [3:0]                          digit [4];
   logic                                c_adv;
   logic                                d_adv;

   assign d_adv    = !d_valid_ff || out_ready;
   assign c_adv    = !c_valid_ff || d_adv;
   assign in_ready = c_adv;

   // apply the reciprocal shift for the chosen point
   always_comb begin
      unique case (in_word.point)
         POINT_DIGIT3: scaled_in = in_word.product[13:0];
         POINT_DIGIT2: scaled_in = in_word.product[41:28];
         POINT_DIGIT1: scaled_in = in_word.product[44:31];
         default:      scaled_in = in_word.product[47:34];
      endcase
   end

   // split into decimal digits, each remainder from the next quotient up
   always_comb begin
      q10   = p10_ff[28:18];
      q100  = p100_ff[28:21];
      q1000 = p1000_ff[28:24];
      rem0  = scaled_ff - (SCALED_W'(q10) * SCALED_W'(10));
      rem1  = q10 - (11'(q100) * 11'd10);
      rem2  = q100 - (8'(q1000) * 8'd10);
      digit[0] = rem0[3:0];
      digit[1] = rem1[3:0];
      digit[2] = rem2[3:0];
      digit[3] = q1000[3:0];
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         frames_in[i] = (i < 4) ? seg_code(digit[i]) : seg_code(4'd0);
         if (i == int'(point_c_ff)) begin
            frames_in[i][SEG_POINT_BIT] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (c_adv) begin
            c_valid_ff <= in_valid;
         end
         if (d_adv) begin
            d_valid_ff <= c_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (c_adv) begin
         scaled_ff  <= scaled_in;
         p10_ff     <= SMALL_PROD_W'(scaled_in) * SMALL_PROD_W'(DIV10_MULT);
         p100_ff    <= SMALL_PROD_W'(scaled_in) * SMALL_PROD_W'(DIV100_MULT);
         p1000_ff   <= SMALL_PROD_W'(scaled_in) * SMALL_PROD_W'(DIV1000_MULT);
         point_c_ff <= in_word.point;
      end
      if (d_adv) begin
         frames_ff <= frames_in;
      end
   end

   assign out_valid  = d_valid_ff;
   assign out_frames = frames_ff;

endmodule

// ===== design/autoseg_frames.sv =====
module autoseg_frames #(
   parameter int DIGIT_COUNT = 4
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             in_valid,
   output logic                                             in_ready,
   input  logic [DIGIT_COUNT-1:0][autoseg_pkg::SEG_W-1:0]   in_frames,
   output logic                                             out_valid,
   input  logic                                             out_ready,
   output logic [autoseg_pkg::SEG_W-1:0]                    out_segments,
   output logic [1:0]                                       out_position,
   output logic                                             out_last
);
   import autoseg_pkg::*;

   localparam int CNT_W = $clog2(DIGIT_COUNT + 1);

   logic [DIGIT_COUNT-1:0][SEG_W-1:0]   frame_store_ff;
   logic [CNT_W-1:0]                    count_ff;
   logic [1:0]                          frame_index_ff;
   logic                                valid_ff;
   logic                                last;
   logic                                take;
   logic                                load;

   assign last     = (count_ff == CNT_W'(DIGIT_COUNT - 1));
   assign take     = valid_ff && out_ready;
   assign load     = !valid_ff || (out_ready && last);
   assign in_ready = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= 1'b0;
         count_ff       <= '0;
         frame_index_ff <= '0;
      end else if (load) begin
         valid_ff       <= in_valid;
         count_ff       <= '0;
         frame_index_ff <= '0;
      end else if (take) begin
         count_ff       <= count_ff + CNT_W'(1);
         frame_index_ff <= frame_index_ff + 2'd1;
      end
   end

   // advance the store one word per delivered frame
   always_ff @(posedge clock) begin
      if (load) begin
         frame_store_ff <= in_frames;
      end else if (take) begin
         frame_store_ff <= frame_store_ff >> SEG_W;
      end
   end

   assign out_valid    = valid_ff;
   assign out_segments = frame_store_ff[0];
   assign out_position = frame_index_ff;
   assign out_last     = last;

endmodule

// ===== design/autorange_seven_segment_display.sv =====
// channel  direction  handshake              payload
// req      in         req_valid/req_ready    req_value_milli
// rsp      out        rsp_valid/rsp_ready    rsp_segments, rsp_digit_position, rsp_last_digit
//
// Each value yields DIGIT_COUNT words, one per cycle unless rsp stalls; the frame serializer
// at the rsp port takes a new value only as the last word of the one before is taken.
// After a value is accepted, its first word passes three more pipeline stages plus
// the serializer register. Synchronous reset clears all valid bits and counters.
// A stall on rsp holds every stage that is full; empty stages keep filling.
module autorange_seven_segment_display #(
   parameter int DIGIT_COUNT = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [autoseg_pkg::VALUE_W-1:0]     req_value_milli,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [autoseg_pkg::SEG_W-1:0]       rsp_segments,
   output logic [1:0]                          rsp_digit_position,
   output logic                                rsp_last_digit
);
   import autoseg_pkg::*;

   range_word_type                      range_word;
   logic                                range_valid;
   logic                                range_ready;
   logic [DIGIT_COUNT-1:0][SEG_W-1:0]   frames;
   logic                                frames_valid;
   logic                                frames_ready;

   autoseg_range u_range (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_value  (req_value_milli),
      .out_valid (range_valid),
      .out_ready (range_ready),
      .out_word  (range_word)
   );

   autoseg_digits #(
      .DIGIT_COUNT (DIGIT_COUNT)
   ) u_digits (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (range_valid),
      .in_ready   (range_ready),
      .in_word    (range_word),
      .out_valid  (frames_valid),
      .out_ready  (frames_ready),
      .out_frames (frames)
   );

   autoseg_frames #(
      .DIGIT_COUNT (DIGIT_COUNT)
   ) u_frames (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (frames_valid),
      .in_ready     (frames_ready),
      .in_frames    (frames),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out_segments (rsp_segments),
      .out_position (rsp_digit_position),
      .out_last     (rsp_last_digit)
   );

endmodule

// ===== tb/sv/autorange_seven_segment_display_tb.sv =====
module autorange_seven_segment_display_tb;
   import autoseg_pkg::*;

   localparam int DIGITS         = 4;
   localparam int HALF_PERIOD    = 6;
   localparam int RESET_CYCLES   = 9;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 12;

   // active-low patterns for 0..9
   localparam logic [SEG_W-1:0] DIGIT_SEGMENTS [10] = '{
      8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
   };

   typedef struct {
      logic [SEG_W-1:0] segments;
      logic [1:0]       position;
      logic             last;
   } digit_word_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [VALUE_W-1:0]   req_value_milli = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [SEG_W-1:0]     rsp_segments;
   logic [1:0]           rsp_digit_position;
   logic                 rsp_last_digit;

   digit_word_type pending_words[$];
   int          errors = 0;
   int          values_sent = 0;
   int          words_checked = 0;
   int          clamped_sent = 0;
   int          stall_left = 0;
   int          idle_cycles = 0;
   bit          gaps_on = 1'b1;

   autorange_seven_segment_display #(.DIGIT_COUNT(DIGITS)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_value_milli   (req_value_milli),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_segments      (rsp_segments),
      .rsp_digit_position(rsp_digit_position),
      .rsp_last_digit    (rsp_last_digit)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic int unsigned scale_down(input int unsigned x);
      return x / 10;
   endfunction

   // segment bytes of the four digits, index 0 least significant
   function automatic logic [DIGITS-1:0][SEG_W-1:0] display_frames(
      input logic [VALUE_W-1:0] value
   );
      logic [VALUE_W-1:0]             v;
      point_type                      point;
      int unsigned                    scaled;
      logic [DIGITS-1:0][SEG_W-1:0]   frames;
      v = (value > VALUE_MAX) ? VALUE_MAX : value;
      if (v <= POINT_LIMIT_3)
         point = POINT_DIGIT3;
      else if (v <= POINT_LIMIT_2)
         point = POINT_DIGIT2;
      else if (v <= POINT_LIMIT_1)
         point = POINT_DIGIT1;
      else
         point = POINT_DIGIT0;
      case (point)
         POINT_DIGIT3: scaled = v;
         POINT_DIGIT2: scaled = v / 10;
         POINT_DIGIT1: scaled = v / 100;
         default:      scaled = v / 1000;
      endcase
      for (int i = 0; i < DIGITS; i++) begin
         frames[i] = DIGIT_SEGMENTS[scaled % 10];
         scaled = scale_down(scaled);
         if (i == int'(point))
            frames[i][SEG_POINT_BIT] = 1'b0;
      end
      return frames;
   endfunction

   function automatic int pick_gap();
      int r;
      if (!gaps_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int pick_stall();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Valid stays high after a word is taken when no gap follows; the caller
   // drops it with release_req before anything other than another send.
   task automatic send_value(input logic [VALUE_W-1:0] value);
      logic [DIGITS-1:0][SEG_W-1:0] frames;
      int                           gap;
      req_valid       <= 1'b1;
      req_value_milli <= value;
      do
         @(posedge clock);
      while (!req_ready);
      frames = display_frames(value);
      for (int i = 0; i < DIGITS; i++)
         pending_words.push_back('{segments: frames[i], position: i[1:0],
                                   last: (i == DIGITS - 1)});
      values_sent++;
      if (value > VALUE_MAX)
         clamped_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic release_req();
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_words.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_directed_values();
      logic [VALUE_W-1:0] values [$];
      values = '{24'd0, 24'd1, 24'd5, 24'd123, 24'd4567, 24'd9899, 24'd9900, 24'd9901,
                 24'd9999, 24'd99900, 24'd99901, 24'd99999, 24'd999900, 24'd999901,
                 24'd999999, 24'd1234567, 24'd8888888, 24'd9999999, 24'd10000000,
                 24'h555555, 24'hAAAAAA, 24'h800000, 24'hFFFFFF};
      foreach (values[i])
         send_value(values[i]);
   endtask

   task automatic test_point_thresholds(input int count);
      logic [VALUE_W-1:0] limits [4];
      logic [VALUE_W-1:0] base;
      limits = '{POINT_LIMIT_3, POINT_LIMIT_2, POINT_LIMIT_1, VALUE_MAX};
      repeat (count) begin
         base = limits[$urandom_range(0, 3)];
         send_value(VALUE_W'(base + $urandom_range(0, 20) - 10));
      end
   endtask

   task automatic test_random_values(input int count);
      logic [VALUE_W-1:0] v;
      repeat (count) begin
         case ($urandom_range(0, 4))
            0:       v = VALUE_W'($urandom_range(0, 9900));
            1:       v = VALUE_W'($urandom_range(9901, 99900));
            2:       v = VALUE_W'($urandom_range(99901, 999900));
            3:       v = VALUE_W'($urandom_range(999901, 9999999));
            default: v = VALUE_W'($urandom_range(10000000, 24'hFFFFFF));
         endcase
         send_value(v);
      end
   endtask

   task automatic test_back_to_back(input int count);
      gaps_on = 1'b0;
      repeat (count)
         send_value(VALUE_W'($urandom_range(0, 24'hFFFFFF)));
      gaps_on = 1'b1;
   endtask

   task automatic test_drain_pause(input int count);
      repeat (count)
         send_value(VALUE_W'($urandom_range(0, 9999999)));
      // hold off until every word is back, then resume
      release_req();
      wait_drained();
      repeat (count)
         send_value(VALUE_W'($urandom_range(0, 9999999)));
   endtask

   // output side: check each word taken, then pick next cycle's ready
   always @(posedge clock) begin
      digit_word_type want;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_words.size() == 0) begin
               $error("unexpected word: segments %02h position %0d last %0b",
                      rsp_segments, rsp_digit_position, rsp_last_digit);
               errors++;
            end else begin
               want = pending_words.pop_front();
               if (rsp_segments !== want.segments) begin
                  $error("segments: expected %02h, got %02h", want.segments, rsp_segments);
                  errors++;
               end
               if (rsp_digit_position !== want.position) begin
                  $error("digit_position: expected %0d, got %0d",
                         want.position, rsp_digit_position);
                  errors++;
               end
               if (rsp_last_digit !== want.last) begin
                  $error("last_digit: expected %0b, got %0b", want.last, rsp_last_digit);
                  errors++;
               end
               words_checked++;
            end
         end
         if (stall_left > 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
         end else if (gaps_on && $urandom_range(0, 99) < 20) begin
            rsp_ready  <= 1'b0;
            stall_left <= pick_stall() - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_values();
      test_point_thresholds(60);
      test_random_values(200);
      test_back_to_back(60);
      test_drain_pause(20);
      release_req();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d values (%0d above full scale) over all four point positions,",
               values_sent, clamped_sent);
      $display("with threshold edges, back-to-back bursts and a drain pause; %0d words checked.",
               words_checked);
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
design/autoseg_pkg.sv
design/autoseg_range.sv
design/autoseg_digits.sv
design/autoseg_frames.sv
design/autorange_seven_segment_display.sv
tb/sv/autorange_seven_segment_display_tb.sv
